[src/hsvm_pkg.sv]
package hsvm_pkg;

	localparam int unsigned FracBits = 12;
	localparam int unsigned SatNum   = 1044480;
	localparam int unsigned HueNum   = 122880;
	localparam int unsigned HueWrap  = 180;
	localparam int unsigned SatRecipW = 20;
	localparam int unsigned HueRecipW = 17;
	localparam int unsigned NumW      = 12;

	typedef enum logic [1:0] {
		REG_HUE_LOW  = 2'd0,
		REG_HUE_HIGH = 2'd1,
		REG_SAT_LOW  = 2'd2,
		REG_SAT_HIGH = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [7:0] hue_low;
		logic [7:0] hue_high;
		logic [7:0] sat_low;
		logic [7:0] sat_high;
	} thresh_t;

endpackage

[src/hsvm_cfg.sv]
module hsvm_cfg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [1:0]       wr_index,
	input  logic [7:0]       wr_data,
	output hsvm_pkg::thresh_t thr
);

	hsvm_pkg::thresh_t thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.hue_low  <= 8'd160;
			thr_q.hue_high <= 8'd10;
			thr_q.sat_low  <= 8'd25;
			thr_q.sat_high <= 8'd166;
		end else if (wr_en) begin
			unique case (hsvm_pkg::reg_index_t'(wr_index))
				hsvm_pkg::REG_HUE_LOW:  thr_q.hue_low  <= wr_data;
				hsvm_pkg::REG_HUE_HIGH: thr_q.hue_high <= wr_data;
				hsvm_pkg::REG_SAT_LOW:  thr_q.sat_low  <= wr_data;
				hsvm_pkg::REG_SAT_HIGH: thr_q.sat_high <= wr_data;
				default: thr_q <= thr_q;
			endcase
		end
	end

	assign thr = thr_q;

endmodule

[src/hsv_hue_saturation_range_mask.sv]
// An accepted input beat is registered in each stage in turn, and its result is
// held in the stage 4 register that drives the outputs.
// Throughput: one pixel per clock; a stalled output holds its beat while
// earlier stages keep filling any bubbles ahead of it.
// Stages: min/max and hue numerator, reciprocal lookup, multiply, round and test.
// Reset clears all stage valid bits and loads the default thresholds.
module hsv_hue_saturation_range_mask (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] blue,
	input  logic [7:0] green,
	input  logic [7:0] red,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       in_range,
	output logic [7:0] hue,
	output logic [7:0] saturation,
	output logic [7:0] brightness,
	input  logic       wr_en,
	input  logic [1:0] wr_index,
	input  logic [7:0] wr_data
);

	localparam int unsigned NW = hsvm_pkg::NumW;
	localparam int unsigned SW = hsvm_pkg::SatRecipW;
	localparam int unsigned HW = hsvm_pkg::HueRecipW;
	localparam int unsigned SatProdW = 8 + SW;
	localparam int unsigned HueProdW = NW + HW + 1;
	localparam int unsigned HueShW   = HueProdW - hsvm_pkg::FracBits;

	hsvm_pkg::thresh_t thr;

	hsvm_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.thr      (thr)
	);

	// reciprocal tables: round(SatNum / v) and round(HueNum / d), zero at index 0
	logic [SW-1:0] sat_recip [256];
	logic [HW-1:0] hue_recip [256];

	for (genvar gi = 0; gi < 256; gi++) begin : g_recip
		localparam int unsigned Den  = (gi == 0) ? 1 : 2 * gi;
		localparam int unsigned SatR = (gi == 0) ? 0 : (2 * hsvm_pkg::SatNum + gi) / Den;
		localparam int unsigned HueR = (gi == 0) ? 0 : (2 * hsvm_pkg::HueNum + gi) / Den;
		assign sat_recip[gi] = SW'(SatR);
		assign hue_recip[gi] = HW'(HueR);
	end

	// handshake: each stage moves when empty or when the next one moves
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	assign rdy4     = !valid_s4 || !out_stall;
	assign rdy3     = !valid_s3 || rdy4;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign in_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
		end
	end

	// stage 1: max, min, chroma, hue numerator
	logic [7:0] mx, mn, bg_max, bg_min;
	logic signed [NW-1:0] bs, gs, rs, d_ext, num;

	always_comb begin
		bg_max = (green > blue) ? green : blue;
		mx     = (red > bg_max) ? red : bg_max;
		bg_min = (green < blue) ? green : blue;
		mn     = (red < bg_min) ? red : bg_min;
		bs     = signed'({{(NW-8){1'b0}}, blue});
		gs     = signed'({{(NW-8){1'b0}}, green});
		rs     = signed'({{(NW-8){1'b0}}, red});
		d_ext  = signed'({{(NW-8){1'b0}}, 8'(mx - mn)});
		priority if (mx == red) begin
			num = gs - bs;
		end else if (mx == green) begin
			num = bs - rs + (d_ext <<< 1);
		end else begin
			num = rs - gs + (d_ext <<< 2);
		end
	end

	logic [7:0] v_s1, d_s1;
	logic signed [NW-1:0] num_s1;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			v_s1   <= mx;
			d_s1   <= 8'(mx - mn);
			num_s1 <= num;
		end
	end

	// stage 2: reciprocal lookup
	logic [7:0] v_s2, d_s2;
	logic signed [NW-1:0] num_s2;
	logic [SW-1:0] srec_s2;
	logic [HW-1:0] hrec_s2;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			v_s2    <= v_s1;
			d_s2    <= d_s1;
			num_s2  <= num_s1;
			srec_s2 <= sat_recip[v_s1];
			hrec_s2 <= hue_recip[d_s1];
		end
	end

	// stage 3: products
	logic [7:0] v_s3;
	logic [SatProdW-1:0] sprod_s3;
	logic signed [HueProdW-1:0] hprod_s3;

	always_ff @(posedge clk) begin
		if (rdy3) begin
			v_s3     <= v_s2;
			sprod_s3 <= SatProdW'(d_s2) * SatProdW'(srec_s2);
			hprod_s3 <= HueProdW'(num_s2) * signed'({1'b0, hrec_s2});
		end
	end

	// stage 4: round, wrap, clamp, range test
	logic [SatProdW:0] ssum;
	logic [SatProdW-hsvm_pkg::FracBits:0] sval;
	logic signed [HueProdW-1:0] hsum;
	logic signed [HueShW-1:0] hsh, hwr;
	logic [7:0] h8, s8;
	logic hue_ok, sat_ok;

	always_comb begin
		ssum = (SatProdW+1)'(sprod_s3) + (SatProdW+1)'(1 << (hsvm_pkg::FracBits - 1));
		sval = ssum[SatProdW:hsvm_pkg::FracBits];
		s8   = (sval > 255) ? 8'd255 : sval[7:0];
		hsum = hprod_s3 + HueProdW'(1 << (hsvm_pkg::FracBits - 1));
		hsh  = hsum[HueProdW-1:hsvm_pkg::FracBits];
		hwr  = hsh[HueShW-1] ? hsh + HueShW'(hsvm_pkg::HueWrap) : hsh;
		priority if (hwr[HueShW-1]) begin
			h8 = 8'd0;
		end else if (hwr > 255) begin
			h8 = 8'd255;
		end else begin
			h8 = hwr[7:0];
		end
		if (thr.hue_low < thr.hue_high) begin
			hue_ok = (h8 > thr.hue_low) && (h8 <= thr.hue_high);
		end else begin
			hue_ok = (h8 > thr.hue_low) || (h8 <= thr.hue_high);
		end
		sat_ok = (s8 > thr.sat_low) && (s8 <= thr.sat_high);
	end

	logic       in_range_s4;
	logic [7:0] hue_s4, sat_s4, v_s4;

	always_ff @(posedge clk) begin
		if (rdy4) begin
			in_range_s4 <= hue_ok && sat_ok;
			hue_s4      <= h8;
			sat_s4      <= s8;
			v_s4        <= v_s3;
		end
	end

	assign out_valid  = valid_s4;
	assign in_range   = in_range_s4;
	assign hue        = hue_s4;
	assign saturation = sat_s4;
	assign brightness = v_s4;

endmodule

[src/hsvm_checker.sv]
module hsvm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       in_range,
	input logic [7:0] hue,
	input logic [7:0] saturation,
	input logic [7:0] brightness
);

	// a stalled result beat stays on the port
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped under stall");

	// black pixel has no saturation
	a_black_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && brightness == 8'd0 |-> saturation == 8'd0)
		else $error("nonzero saturation on black pixel");

	// zero saturation only for grey, and grey has hue zero
	a_grey_hue: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturation == 8'd0 |-> hue == 8'd0)
		else $error("grey pixel with nonzero hue");

	a_hue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hue < 8'd180)
		else $error("hue out of half-degree range");

	// lower saturation bound is exclusive, so a hit never has zero saturation
	a_hit_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_range |-> saturation != 8'd0)
		else $error("flagged pixel with zero saturation");

endmodule

bind hsv_hue_saturation_range_mask hsvm_checker u_hsvm_checker (.*);

[tb/sv/testbench.sv]
module testbench;
	import hsvm_pkg::*;

	localparam int LATENCY = 4;
	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASES = 8;
	localparam int PHASE_BEATS = 135;
	localparam int HOLD_AT = 400;
	localparam int HOLD_CYCLES = 60;
	localparam int DIR_COUNT = 20;

	typedef struct packed {
		logic       flag;
		logic [7:0] h;
		logic [7:0] s;
		logic [7:0] v;
	} hsv_t;

	typedef struct packed {
		logic [7:0] b;
		logic [7:0] g;
		logic [7:0] r;
		logic       typed;
		hsv_t       want;
	} dir_row_t;

	// b, g, r; typed rows carry the result under reset thresholds
	localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
		'{8'd0,   8'd0,   8'd0,   1'b1, '{1'b0, 8'd0,   8'd0,   8'd0}},
		'{8'd255, 8'd255, 8'd255, 1'b1, '{1'b0, 8'd0,   8'd0,   8'd255}},
		'{8'd128, 8'd128, 8'd128, 1'b1, '{1'b0, 8'd0,   8'd0,   8'd128}},
		'{8'd1,   8'd1,   8'd1,   1'b1, '{1'b0, 8'd0,   8'd0,   8'd1}},
		'{8'd0,   8'd0,   8'd255, 1'b1, '{1'b0, 8'd0,   8'd255, 8'd255}},
		'{8'd0,   8'd255, 8'd0,   1'b1, '{1'b0, 8'd60,  8'd255, 8'd255}},
		'{8'd255, 8'd0,   8'd0,   1'b1, '{1'b0, 8'd120, 8'd255, 8'd255}},
		'{8'd200, 8'd0,   8'd255, 1'b0, '0},
		'{8'd1,   8'd0,   8'd1,   1'b0, '0},
		'{8'd0,   8'd1,   8'd1,   1'b0, '0},
		'{8'd255, 8'd255, 8'd0,   1'b0, '0},
		'{8'd130, 8'd120, 8'd200, 1'b0, '0},
		'{8'd0,   8'd0,   8'd1,   1'b0, '0},
		'{8'd5,   8'd0,   8'd255, 1'b0, '0},
		'{8'd1,   8'd0,   8'd255, 1'b0, '0},
		'{8'd255, 8'd0,   8'd255, 1'b0, '0},
		'{8'd0,   8'd255, 8'd255, 1'b0, '0},
		'{8'd255, 8'd254, 8'd0,   1'b0, '0},
		'{8'd85,  8'd170, 8'd255, 1'b0, '0},
		'{8'd254, 8'd255, 8'd255, 1'b0, '0}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] blue = '0;
	logic [7:0] green = '0;
	logic [7:0] red = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       in_range;
	logic [7:0] hue;
	logic [7:0] saturation;
	logic [7:0] brightness;
	logic       wr_en = 1'b0;
	logic [1:0] wr_index = REG_HUE_LOW;
	logic [7:0] wr_data = '0;

	thresh_t cur_thresh = '{8'd160, 8'd10, 8'd25, 8'd166};
	hsv_t    pending_hsv [$];
	int      px_sent = 0;
	int      hsv_checked = 0;
	int      mismatches = 0;
	int      cycles = 0;
	int      settings_used = 1;
	bit      tail = 1'b0;
	int      tx_calm = 0;

	hsv_hue_saturation_range_mask u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.blue(blue), .green(green), .red(red),
		.out_valid(out_valid), .out_stall(out_stall),
		.in_range(in_range), .hue(hue), .saturation(saturation), .brightness(brightness),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL hsv_hue_saturation_range_mask");
			$finish;
		end
	end

	// fixed-point BGR to HSV plus threshold test against the current settings
	function automatic hsv_t hsv_of_pixel(input logic [7:0] b, input logic [7:0] g,
			input logic [7:0] r);
		hsv_t res;
		int vb, vg, vr, mx, mn, d, s_recip, h_recip, num, h, s;
		bit hue_ok, sat_ok;
		vb = b;
		vg = g;
		vr = r;
		mx = vb;
		mn = vb;
		if (vg > mx) mx = vg;
		if (vr > mx) mx = vr;
		if (vg < mn) mn = vg;
		if (vr < mn) mn = vr;
		d = mx - mn;
		s_recip = (mx == 0) ? 0 : int'((2 * SatNum + mx) / (2 * mx));
		h_recip = (d == 0) ? 0 : int'((2 * HueNum + d) / (2 * d));
		s = (d * s_recip + (1 << (FracBits - 1))) >>> FracBits;
		if (mx == vr)
			num = vg - vb;
		else if (mx == vg)
			num = vb - vr + 2 * d;
		else
			num = vr - vg + 4 * d;
		h = (num * h_recip + (1 << (FracBits - 1))) >>> FracBits;
		if (h < 0) h = h + int'(HueWrap);
		if (h < 0) h = 0;
		if (h > 255) h = 255;
		if (s > 255) s = 255;
		if (cur_thresh.hue_low < cur_thresh.hue_high)
			hue_ok = (h > int'(cur_thresh.hue_low)) && (h <= int'(cur_thresh.hue_high));
		else
			hue_ok = (h > int'(cur_thresh.hue_low)) || (h <= int'(cur_thresh.hue_high));
		sat_ok = (s > int'(cur_thresh.sat_low)) && (s <= int'(cur_thresh.sat_high));
		res.flag = hue_ok && sat_ok;
		res.h = h[7:0];
		res.s = s[7:0];
		res.v = mx[7:0];
		return res;
	endfunction

	function automatic thresh_t thresh_for_phase(input int ph);
		thresh_t t;
		case (ph)
			1: t = '{8'd0, 8'd180, 8'd0, 8'd255};
			2: t = '{8'd255, 8'd0, 8'd0, 8'd255};
			3: t = '{8'd90, 8'd90, 8'd100, 8'd100};
			4: t = '{8'd179, 8'd0, 8'd0, 8'd254};
			5: t = '{8'd20, 8'd40, 8'd50, 8'd200};
			6: t = '{8'd200, 8'd255, 8'd10, 8'd0};
			default: begin
				t.hue_low  = 8'($urandom_range(0, 180));
				t.hue_high = 8'($urandom_range(0, 180));
				t.sat_low  = 8'($urandom_range(0, 120));
				t.sat_high = 8'($urandom_range(100, 255));
			end
		endcase
		return t;
	endfunction

	task automatic pick_pixel(output logic [7:0] b, output logic [7:0] g,
			output logic [7:0] r);
		int m, x, k;
		m = $urandom_range(0, 255);
		x = $urandom_range(0, m);
		k = $urandom_range(0, 2);
		b = 8'($urandom);
		g = 8'($urandom);
		r = 8'($urandom);
		case ($urandom_range(0, 9))
			0: begin
				g = b;
				r = b;
			end
			1: begin
				// near grey: tiny spread, hue reciprocal at its largest
				g = b ^ 8'($urandom_range(0, 3));
				r = b ^ 8'($urandom_range(0, 3));
			end
			2: begin
				b = $urandom_range(0, 1) ? 8'd255 : 8'd0;
				g = $urandom_range(0, 1) ? 8'd255 : 8'd0;
				r = $urandom_range(0, 1) ? 8'd255 : 8'd0;
			end
			3: begin
				// two channels share the maximum
				b = (k == 0) ? 8'(x) : 8'(m);
				g = (k == 1) ? 8'(x) : 8'(m);
				r = (k == 2) ? 8'(x) : 8'(m);
			end
			default: ;
		endcase
	endtask

	task automatic push_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
			input logic typed, input hsv_t want);
		int gap;
		gap = 0;
		if (!tail) begin
			if (tx_calm > 0)
				tx_calm--;
			else if ($urandom_range(0, 2) == 0)
				gap = $urandom_range(1, 14);
			else
				tx_calm = $urandom_range(0, 30);
		end
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		blue <= b;
		green <= g;
		red <= r;
		do @(posedge clk); while (in_stall);
		pending_hsv.push_back(typed ? want : hsv_of_pixel(b, g, r));
		px_sent++;
	endtask

	// drop valid, drain all expected beats, then give the pipe time to empty
	task automatic drain_pipe();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_hsv.size() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [7:0] val);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		case (idx)
			REG_HUE_LOW:  cur_thresh.hue_low = val;
			REG_HUE_HIGH: cur_thresh.hue_high = val;
			REG_SAT_LOW:  cur_thresh.sat_low = val;
			REG_SAT_HIGH: cur_thresh.sat_high = val;
		endcase
	endtask

	task automatic load_thresh(input thresh_t t);
		drain_pipe();
		write_reg(REG_HUE_LOW, t.hue_low);
		write_reg(REG_HUE_HIGH, t.hue_high);
		write_reg(REG_SAT_LOW, t.sat_low);
		write_reg(REG_SAT_HIGH, t.sat_high);
		@(negedge clk);
		wr_en <= 1'b0;
		settings_used++;
	endtask

	// receiver: random stall bursts, calm runs, one long hold to back up the pipe
	int rx_burst = 0;
	int rx_run = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	always @(negedge clk) begin
		if (tail) begin
			out_stall <= 1'b0;
		end else if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (!hold_done && px_sent >= HOLD_AT) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else if (rx_burst > 0) begin
			out_stall <= 1'b1;
			rx_burst--;
		end else if (rx_run > 0) begin
			out_stall <= 1'b0;
			rx_run--;
		end else if ($urandom_range(0, 2) == 0) begin
			rx_burst = $urandom_range(1, 14) - 1;
			out_stall <= 1'b1;
		end else begin
			rx_run = $urandom_range(0, 40);
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		hsv_t exp_px;
		if (out_valid && !out_stall) begin
			if (pending_hsv.size() == 0) begin
				$error("unexpected result beat: hue %0d sat %0d val %0d", hue, saturation,
					brightness);
				mismatches++;
			end else begin
				exp_px = pending_hsv.pop_front();
				hsv_checked++;
				if (in_range !== exp_px.flag) begin
					$error("in_range: expected %0d, got %0d", exp_px.flag, in_range);
					mismatches++;
				end
				if (hue !== exp_px.h) begin
					$error("hue: expected %0d, got %0d", exp_px.h, hue);
					mismatches++;
				end
				if (saturation !== exp_px.s) begin
					$error("saturation: expected %0d, got %0d", exp_px.s, saturation);
					mismatches++;
				end
				if (brightness !== exp_px.v) begin
					$error("brightness: expected %0d, got %0d", exp_px.v, brightness);
					mismatches++;
				end
			end
		end
	end

	initial begin
		logic [7:0] b, g, r;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_COUNT; i++)
			push_pixel(DIR_ROWS[i].b, DIR_ROWS[i].g, DIR_ROWS[i].r, DIR_ROWS[i].typed,
				DIR_ROWS[i].want);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0)
				load_thresh(thresh_for_phase(ph));
			if (ph == PHASES - 1)
				tail = 1'b1;
			for (int k = 0; k < PHASE_BEATS; k++) begin
				if (ph == 4 && k == PHASE_BEATS / 2)
					drain_pipe();
				pick_pixel(b, g, r);
				push_pixel(b, g, r, 1'b0, '0);
			end
		end

		drain_pipe();
		repeat (LATENCY * 2) @(posedge clk);
		$display("Sent %0d pixels under %0d threshold settings; %0d result beats checked.",
			px_sent, settings_used, hsv_checked);
		if (mismatches == 0 && pending_hsv.size() == 0)
			$display("PASS hsv_hue_saturation_range_mask");
		else
			$display("FAIL hsv_hue_saturation_range_mask");
		$finish;
	end

endmodule

[sim.f]
src/hsvm_pkg.sv
src/hsvm_cfg.sv
src/hsv_hue_saturation_range_mask.sv
src/hsvm_checker.sv
tb/sv/testbench.sv
